@@ hdl/mbsig_pkg.sv @@
package mbsig_pkg;

	localparam int COORD_W  = 10;
	localparam int STRIDE_W = 11;
	localparam int IDX_W    = 30;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = STRIDE_W;

	// plane product, plane/row sum
	localparam int PZ_W  = STRIDE_W + COORD_W;
	localparam int SUM_W = PZ_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_START    = 3'd0,
		REG_X_END      = 3'd1,
		REG_Y_START    = 3'd2,
		REG_Y_END      = 3'd3,
		REG_Z_START    = 3'd4,
		REG_Z_END      = 3'd5,
		REG_ROW_LEN    = 3'd6,
		REG_PLANE_ROWS = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic accept;   // latch input item, apply restart
		logic mul_pz;   // y + plane_rows*z
		logic mul_row;  // row_len * (...)
		logic finish;   // load result, step position
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} dp_status_t;

endpackage

@@ hdl/mbsig_obstacle_if.sv @@
interface mbsig_obstacle_if;
	logic                          valid;
	logic                          ready;
	logic [mbsig_pkg::IDX_W-1:0]   obstacle_index;
	logic                          obstacle_valid;
	logic                          restart;

	modport source (output valid, output obstacle_index, output obstacle_valid,
		output restart, input ready);
	modport sink (input valid, input obstacle_index, input obstacle_valid,
		input restart, output ready);
endinterface

@@ hdl/mbsig_cell_if.sv @@
interface mbsig_cell_if;
	logic                          valid;
	logic                          ready;
	logic [mbsig_pkg::IDX_W-1:0]   cell_index;
	logic                          cell_emitted;
	logic                          obstacle_consumed;
	logic                          last_cell;

	modport source (output valid, output cell_index, output cell_emitted,
		output obstacle_consumed, output last_cell, input ready);
	modport sink (input valid, input cell_index, input cell_emitted,
		input obstacle_consumed, input last_cell, output ready);
endinterface

@@ hdl/mbsig_ctrl.sv @@
module mbsig_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  mbsig_pkg::dp_status_t   status,
	output mbsig_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PLANE,
		ST_ROW,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   finish;

	assign finish   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept  = in_valid && (state_q == ST_IDLE);
		cmd.mul_pz  = (state_q == ST_PLANE);
		cmd.mul_row = (state_q == ST_ROW);
		cmd.finish  = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_PLANE;
				end
				ST_PLANE: begin
					// no scan active: result is all zero, skip the multiplies
					state_q <= status.scan_done ? ST_EMIT : ST_ROW;
				end
				ST_ROW: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (finish) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

@@ hdl/mbsig_datapath.sv @@
module mbsig_datapath #(
	parameter int DIM_MAX = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mbsig_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbsig_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [mbsig_pkg::IDX_W-1:0]         obstacle_index,
	input  logic                                obstacle_valid,
	input  logic                                restart,
	input  mbsig_pkg::ctrl_cmd_t                cmd,
	output mbsig_pkg::dp_status_t               status,
	output logic [mbsig_pkg::IDX_W-1:0]         cell_index,
	output logic                                cell_emitted,
	output logic                                obstacle_consumed,
	output logic                                last_cell
);

	localparam int CW = mbsig_pkg::COORD_W;
	localparam int SW = mbsig_pkg::STRIDE_W;
	localparam int IW = mbsig_pkg::IDX_W;

	logic [CW-1:0] x_start_q, x_end_q, y_start_q, y_end_q, z_start_q, z_end_q;
	logic [SW-1:0] row_len_q, plane_rows_q;
	logic [CW-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic          scan_done_q;

	logic [IW-1:0] head_q;
	logic          head_valid_q;

	logic [mbsig_pkg::SUM_W-1:0] sum_s1;
	logic [IW-1:0]               prod_s2;

	logic [SW-1:0] rl, pr;
	logic [IW-1:0] idx;
	logic          hit, at_x, at_y, at_z, last;

	mbsig_pkg::cfg_reg_t cfg_sel;
	assign cfg_sel = mbsig_pkg::cfg_reg_t'(cfg_index);

	// strides above DIM_MAX saturate
	assign rl = (int'({21'd0, row_len_q}) > DIM_MAX) ? SW'(DIM_MAX) : row_len_q;
	assign pr = (int'({21'd0, plane_rows_q}) > DIM_MAX) ? SW'(DIM_MAX) : plane_rows_q;

	assign idx  = prod_s2 + IW'(pos_x_q);
	assign hit  = head_valid_q && (head_q == idx);
	assign at_x = pos_x_q >= x_end_q;
	assign at_y = pos_y_q >= y_end_q;
	assign at_z = pos_z_q >= z_end_q;
	assign last = at_x && at_y && at_z;

	assign status.scan_done = scan_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_start_q    <= '0;
			x_end_q      <= '0;
			y_start_q    <= '0;
			y_end_q      <= '0;
			z_start_q    <= '0;
			z_end_q      <= '0;
			row_len_q    <= SW'(1);
			plane_rows_q <= SW'(1);
		end else if (cfg_we) begin
			unique case (cfg_sel)
				mbsig_pkg::REG_X_START:    x_start_q    <= cfg_wdata[CW-1:0];
				mbsig_pkg::REG_X_END:      x_end_q      <= cfg_wdata[CW-1:0];
				mbsig_pkg::REG_Y_START:    y_start_q    <= cfg_wdata[CW-1:0];
				mbsig_pkg::REG_Y_END:      y_end_q      <= cfg_wdata[CW-1:0];
				mbsig_pkg::REG_Z_START:    z_start_q    <= cfg_wdata[CW-1:0];
				mbsig_pkg::REG_Z_END:      z_end_q      <= cfg_wdata[CW-1:0];
				mbsig_pkg::REG_ROW_LEN:    row_len_q    <= cfg_wdata;
				mbsig_pkg::REG_PLANE_ROWS: plane_rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_z_q     <= '0;
			scan_done_q <= 1'b1;
		end else if (cmd.accept && restart) begin
			pos_x_q     <= x_start_q;
			pos_y_q     <= y_start_q;
			pos_z_q     <= z_start_q;
			scan_done_q <= (x_start_q > x_end_q) || (y_start_q > y_end_q) ||
				(z_start_q > z_end_q);
		end else if (cmd.finish && !scan_done_q) begin
			priority if (last) begin
				scan_done_q <= 1'b1;
			end else if (!at_x) begin
				pos_x_q <= pos_x_q + CW'(1);
			end else if (!at_y) begin
				pos_x_q <= x_start_q;
				pos_y_q <= pos_y_q + CW'(1);
			end else begin
				pos_x_q <= x_start_q;
				pos_y_q <= y_start_q;
				pos_z_q <= pos_z_q + CW'(1);
			end
		end
	end

	// item latch, index arithmetic, result register
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			head_q       <= obstacle_index;
			head_valid_q <= obstacle_valid;
		end
		if (cmd.mul_pz) begin
			sum_s1 <= mbsig_pkg::SUM_W'(pr * pos_z_q) + mbsig_pkg::SUM_W'(pos_y_q);
		end
		if (cmd.mul_row) begin
			prod_s2 <= IW'(rl * sum_s1);
		end
		if (cmd.finish) begin
			if (scan_done_q) begin
				cell_index        <= '0;
				cell_emitted      <= 1'b0;
				obstacle_consumed <= 1'b0;
				last_cell         <= 1'b0;
			end else begin
				cell_index        <= idx;
				cell_emitted      <= !hit;
				obstacle_consumed <= hit;
				last_cell         <= last;
			end
		end
	end

endmodule

@@ hdl/masked_box_scan_index_generator.sv @@
// Masked box scan index generator.
// Walks a configured 3D box in raster order (x fastest, then y, then z) and
// returns one result item per input item on cell_ch: the linear cell index
// x + row_len*(y + plane_rows*z), whether it was emitted, whether the head
// obstacle from obstacle_ch matched it (and is to be popped), and a flag on
// the box end cell. restart in an input item starts a new scan at the box
// start. Without an active scan the result item is all zero.
// Box bounds and strides are written on the cfg_we/cfg_index/cfg_wdata port;
// the user must do so only while the block is idle; it does not enforce this.
// Timing: an accepted item goes through two multiply steps (plane, then row)
// and then the index add and compare before it shows on cell_ch; with no
// scan active the multiplies are skipped. One item is in work at a time, so
// a new item is taken only once the last one is through, and the pace is
// set by the serial plane and row multiplies.
// The result sits in an output register: if the receiver stalls, the next
// item is still taken and worked up to the output stage, where it waits.
// Reset clears the registers to their defaults (strides 1, bounds 0), puts
// the position at zero with no scan active, and empties the output.
module masked_box_scan_index_generator #(
	parameter int DIM_MAX = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mbsig_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbsig_pkg::CFG_W-1:0]       cfg_wdata,
	mbsig_obstacle_if.sink                    obstacle_ch,
	mbsig_cell_if.source                      cell_ch
);

	mbsig_pkg::ctrl_cmd_t  cmd;
	mbsig_pkg::dp_status_t status;

	// sequencer: handshakes and step order
	mbsig_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (obstacle_ch.valid),
		.in_ready  (obstacle_ch.ready),
		.out_valid (cell_ch.valid),
		.out_ready (cell_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// registers, position counters, index arithmetic, result register
	mbsig_datapath #(
		.DIM_MAX (DIM_MAX)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.obstacle_index    (obstacle_ch.obstacle_index),
		.obstacle_valid    (obstacle_ch.obstacle_valid),
		.restart           (obstacle_ch.restart),
		.cmd               (cmd),
		.status            (status),
		.cell_index        (cell_ch.cell_index),
		.cell_emitted      (cell_ch.cell_emitted),
		.obstacle_consumed (cell_ch.obstacle_consumed),
		.last_cell         (cell_ch.last_cell)
	);

endmodule
